@@ rtl/core/sv39ptw_pkg.sv @@
// shared types, constants and helpers for the sv39 page table walker
package sv39ptw_pkg;

  localparam int TABLE_PAGES = 16;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int STORE_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int ADDR_W = $clog2(STORE_WORDS);
  localparam int TOP_LEVEL = 2;

  // result status codes
  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_VA_RANGE = 3'd1;
  localparam logic [2:0] STATUS_UNMAPPED = 3'd2;
  localparam logic [2:0] STATUS_NO_USER  = 3'd3;
  localparam logic [2:0] STATUS_BAD_PTR  = 3'd4;

  // item actions
  localparam logic ACTION_WRITE     = 1'b0;
  localparam logic ACTION_TRANSLATE = 1'b1;

  // pte flag bits
  localparam int PTE_V_BIT = 0;
  localparam int PTE_U_BIT = 4;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_RESP   = 4'b1000
  } walk_state_t;

  // table index of va at a level
  function automatic logic [8:0] vpn_of(input logic [37:0] va, input logic [1:0] lvl);
    logic [8:0] idx;
    case (lvl)
      2'd0:    idx = va[20:12];
      2'd1:    idx = va[29:21];
      default: idx = {1'b0, va[37:30]};
    endcase
    return idx;
  endfunction

  // va bits below the page size of a level
  function automatic logic [29:0] offset_of(input logic [37:0] va, input logic [1:0] lvl);
    logic [29:0] off;
    case (lvl)
      2'd0:    off = {18'd0, va[11:0]};
      2'd1:    off = {9'd0, va[20:0]};
      default: off = va[29:0];
    endcase
    return off;
  endfunction

endpackage

@@ rtl/core/sv39_page_table_walker.sv @@
// sv39 page table walker with an on-chip page table store
//
// usage:
//   input channel in_valid/in_ready carries one beat per item: a write of one
//   table word (action 0) or a translation of va (action 1)
//   output channel out_valid/out_ready returns one result beat per item
//   cfg_we/cfg_wdata writes root_page, the store page of the root table
// walk:
//   a write or an early fault goes from accept straight to the response state
//   a translation reads one table word per level, from the root level down
//   until a leaf, a fault or the stop level; the table memory has a single
//   read port, reads form a dependent chain and one item is walked at a time
// reset:
//   root_page goes to 0, then a clearing pass zeroes the store one word a
//   cycle, all 8192 words (STORE_WORDS); in_ready stays low meanwhile,
//   configuration writes are taken during the pass
// stall:
//   a finished result sits in the output register while the next item is
//   accepted and walked; the walker holds its own result until out_ready
module sv39_page_table_walker (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [38:0] va,
  input  logic [1:0]  stop_level,
  input  logic        require_user,
  input  logic [12:0] word_index,
  input  logic [63:0] word_data,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [55:0] phys_addr,
  output logic [63:0] entry_word,
  output logic [1:0]  entry_level,
  output logic        is_leaf
);

  localparam int AW = sv39ptw_pkg::ADDR_W;

  sv39ptw_pkg::walk_state_t state, state_next;

  // root table page register
  logic [3:0] root_page;

  // table store: one 64-bit word per entry, registered read
  logic [63:0]   table_mem [sv39ptw_pkg::STORE_WORDS];
  logic [63:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [AW-1:0] rd_addr;

  // clearing pass address
  logic [AW-1:0] clr_addr;

  // walk context
  logic [37:0] va_q;
  logic [1:0]  lvl;
  logic [1:0]  stop_q;
  logic        user_q;

  // pending result, moved to the output register when it is free
  logic [2:0]  res_status;
  logic [55:0] res_pa;
  logic [63:0] res_word;
  logic [1:0]  res_level;
  logic        res_leaf;

  logic        accept;
  logic        out_free;
  logic [1:0]  stop_clamped;
  logic        root_bad;
  logic        widx_ok;

  // lookup decode of the word just read
  logic        pte_v;
  logic        pte_rwx;
  logic        pte_u;
  logic        at_stop;
  logic        ptr_bad;
  logic [55:0] pte_base;
  logic [55:0] leaf_pa;

  assign in_ready = (state == sv39ptw_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign stop_clamped = (stop_level > 2'(sv39ptw_pkg::TOP_LEVEL)) ?
                        2'(sv39ptw_pkg::TOP_LEVEL) : stop_level;
  assign root_bad = (32'(root_page) >= 32'(sv39ptw_pkg::TABLE_PAGES));
  assign widx_ok  = (32'(word_index) < 32'(sv39ptw_pkg::STORE_WORDS));

  assign pte_v    = rdata[sv39ptw_pkg::PTE_V_BIT];
  assign pte_rwx  = |rdata[3:1];
  assign pte_u    = rdata[sv39ptw_pkg::PTE_U_BIT];
  assign at_stop  = (lvl == stop_q);
  assign ptr_bad  = (rdata[63:10] >= 54'(sv39ptw_pkg::TABLE_PAGES));
  assign pte_base = {rdata[53:10], 12'd0};
  assign leaf_pa  = pte_base + 56'(sv39ptw_pkg::offset_of(va_q, lvl));

  // memory write port: clearing pass or write items
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 64'd0;
    if (state == sv39ptw_pkg::ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && action == sv39ptw_pkg::ACTION_WRITE && widx_ok) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(word_index);
      mem_wdata = word_data;
    end
  end

  // read address: root entry on accept, next table entry during lookup
  always_comb begin
    if (state == sv39ptw_pkg::ST_IDLE) begin
      rd_addr = AW'({root_page, sv39ptw_pkg::vpn_of(va[37:0], 2'(sv39ptw_pkg::TOP_LEVEL))});
    end else begin
      rd_addr = AW'({rdata[63:10], sv39ptw_pkg::vpn_of(va_q, lvl - 2'd1)});
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_page <= 4'd0;
    end else if (cfg_we) begin
      root_page <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sv39ptw_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(sv39ptw_pkg::STORE_WORDS - 1)) begin
          state_next = sv39ptw_pkg::ST_IDLE;
        end
      end
      sv39ptw_pkg::ST_IDLE: begin
        if (accept) begin
          if (action == sv39ptw_pkg::ACTION_WRITE || va[38] || root_bad) begin
            state_next = sv39ptw_pkg::ST_RESP;
          end else begin
            state_next = sv39ptw_pkg::ST_LOOKUP;
          end
        end
      end
      sv39ptw_pkg::ST_LOOKUP: begin
        // keep walking only through a valid in-store pointer above the stop level
        if (!pte_v || at_stop || pte_rwx || ptr_bad) begin
          state_next = sv39ptw_pkg::ST_RESP;
        end
      end
      sv39ptw_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = sv39ptw_pkg::ST_IDLE;
        end
      end
      default: state_next = sv39ptw_pkg::ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sv39ptw_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sv39ptw_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == sv39ptw_pkg::ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk context and pending result
  always_ff @(posedge clk) begin
    case (state)
      sv39ptw_pkg::ST_IDLE: begin
        if (accept) begin
          va_q       <= va[37:0];
          lvl        <= 2'(sv39ptw_pkg::TOP_LEVEL);
          stop_q     <= stop_clamped;
          user_q     <= require_user;
          res_status <= sv39ptw_pkg::STATUS_OK;
          res_pa     <= 56'd0;
          res_word   <= 64'd0;
          res_level  <= 2'd0;
          res_leaf   <= 1'b0;
          if (action == sv39ptw_pkg::ACTION_TRANSLATE) begin
            if (va[38]) begin
              res_status <= sv39ptw_pkg::STATUS_VA_RANGE;
            end else if (root_bad) begin
              res_status <= sv39ptw_pkg::STATUS_BAD_PTR;
              res_level  <= 2'(sv39ptw_pkg::TOP_LEVEL);
            end
          end
        end
      end
      sv39ptw_pkg::ST_LOOKUP: begin
        res_word  <= rdata;
        res_level <= lvl;
        res_pa    <= 56'd0;
        res_leaf  <= 1'b0;
        if (!pte_v) begin
          res_status <= sv39ptw_pkg::STATUS_UNMAPPED;
        end else if (at_stop || pte_rwx) begin
          res_leaf <= pte_rwx;
          if (user_q && !pte_u) begin
            res_status <= sv39ptw_pkg::STATUS_NO_USER;
          end else begin
            res_status <= sv39ptw_pkg::STATUS_OK;
            res_pa     <= pte_rwx ? leaf_pa : pte_base;
          end
        end else if (ptr_bad) begin
          res_status <= sv39ptw_pkg::STATUS_BAD_PTR;
        end else begin
          lvl <= lvl - 2'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == sv39ptw_pkg::ST_RESP && out_free) begin
      status      <= res_status;
      phys_addr   <= res_pa;
      entry_word  <= res_word;
      entry_level <= res_level;
      is_leaf     <= res_leaf;
    end
  end

`ifndef NO_ASSERTIONS
  // no item is taken until the store is cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == sv39ptw_pkg::ST_CLEAR) |-> !in_ready)
    else $error("item accepted during clearing pass");

  // the walk never descends below the stop level
  a_level_above_stop: assert property (@(posedge clk) disable iff (rst)
    (state == sv39ptw_pkg::ST_LOOKUP) |-> (lvl >= stop_q))
    else $error("walk went below stop level");

  // a leaf result carries a valid entry with a permission bit
  a_leaf_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_leaf) |-> (entry_word[sv39ptw_pkg::PTE_V_BIT] && (|entry_word[3:1])))
    else $error("leaf result without a valid leaf entry");

  // an unmapped result carries an entry with the valid bit clear
  a_unmapped_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == sv39ptw_pkg::STATUS_UNMAPPED)
      |-> !entry_word[sv39ptw_pkg::PTE_V_BIT])
    else $error("unmapped result with valid entry");

  // a result is only loaded from the response state
  a_out_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == sv39ptw_pkg::ST_RESP))
    else $error("result beat not from response state");
`endif

endmodule
